>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a clocked property; disabled while reset is asserted.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hdl/cemt_pkg.sv
// Types and constants of the cron entry match table.
package cemt_pkg;

    localparam int DEFAULT_ENTRIES = 16;

    localparam logic [1:0] ACT_SCHEDULE      = 2'd0;
    localparam logic [1:0] ACT_REMOVE_ID     = 2'd1;
    localparam logic [1:0] ACT_REMOVE_HANDLE = 2'd2;
    localparam logic [1:0] ACT_TICK          = 2'd3;

    localparam logic [2:0] STAT_SCHEDULED = 3'd0;
    localparam logic [2:0] STAT_BAD_FIELD = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_REMOVED   = 3'd3;
    localparam logic [2:0] STAT_MATCH     = 3'd4;
    localparam logic [2:0] STAT_NO_MATCH  = 3'd5;

    typedef struct packed {
        logic [15:0]        id;
        logic [7:0]         handle;
        logic signed [6:0]  minute;
        logic signed [5:0]  hour;
        logic signed [5:0]  month_day;
        logic signed [4:0]  month;
        logic signed [3:0]  week_day;
    } entry_rec_t;

endpackage

>>> hdl/cron_entry_match_table_top.sv
// Cron entry match table: entry memory, slot scan and result register.
//
// Usage: one request channel (req_valid/req_stall) carries an action with
// time patterns, an entry id and a task handle; one response channel
// (rsp_valid/rsp_stall) returns status, id, handle, removed count and last.
// Schedule stores the patterns in the lowest free slot under the next id;
// remove clears all entries with the given id or handle and answers once;
// tick reports every matching entry in slot order, last set on the final one,
// or a single no-match response.
// Throughput: one request at a time. Remove and tick scan every slot, one
// memory read per cycle while no held response stalls the scan. Schedule
// stops at the first free slot and scans every slot when the table is full;
// a bad field reads no slot. The entry memory has a single read port.
// For remove, tick and a failed schedule, the last response is registered
// after the scan ends and the final compare retires.
// A stalled response holds; the scan waits only when a response is due while
// the register still holds a stalled one. req_stall is high while a request
// is in progress; a new request is taken even while a response still waits.
// Reset: all entries invalid, id counter zero, no response pending; the
// entry memory is not cleared.
module cron_entry_match_table_top
    import cemt_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         action,
    input  logic signed [6:0]  minute,
    input  logic signed [5:0]  hour,
    input  logic signed [5:0]  month_day,
    input  logic signed [4:0]  month,
    input  logic signed [3:0]  week_day,
    input  logic [15:0]        entry_id,
    input  logic [7:0]         task_handle,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [2:0]         status,
    output logic [15:0]        result_id,
    output logic [7:0]         result_handle,
    output logic [4:0]         removed_count,
    output logic               last
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic               bad_reg, bad_next;
    entry_rec_t         req_reg, req_next;
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic               cmp_v_reg, cmp_v_next;
    logic [IW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               pend_v_reg, pend_v_next;
    logic [15:0]        pend_id_reg, pend_id_next;
    logic [7:0]         pend_handle_reg, pend_handle_next;
    logic [15:0]        id_counter_reg, id_counter_next;
    logic               out_v_reg, out_v_next;
    logic [2:0]         out_status_reg, out_status_next;
    logic [15:0]        out_id_reg, out_id_next;
    logic [7:0]         out_handle_reg, out_handle_next;
    logic [4:0]         out_count_reg, out_count_next;
    logic               out_last_reg, out_last_next;

    entry_rec_t         mem [ENTRIES];
    entry_rec_t         rdata_reg;
    entry_rec_t         wr_rec;
    logic               wr_en;
    logic               rd_en;

    logic               field_bad;
    logic               out_free;
    logic               scan_end;
    logic               cmp_ev;
    logic               m_min, m_hr, m_md, m_mo, m_wd;
    logic               tick_hit;
    logic               rem_hit;
    logic               cmp_retire;
    logic               done;
    logic [15:0]        id_new;

    assign field_bad =
        !((&minute)    || (minute    >= 7'sd0 && minute    <= 7'sd59)) ||
        !((&hour)      || (hour      >= 6'sd0 && hour      <= 6'sd23)) ||
        !((&month_day) || (month_day >= 6'sd1 && month_day <= 6'sd31)) ||
        !((&month)     || (month     >= 5'sd1 && month     <= 5'sd12)) ||
        !((&week_day)  || (week_day  >= 4'sd0 && week_day  <= 4'sd6));

    assign out_free = !out_v_reg || !rsp_stall;
    assign scan_end = (rd_idx_reg == CW'(ENTRIES));
    assign cmp_ev   = valid_reg[cmp_idx_reg];
    assign id_new   = id_counter_reg + 16'd1;

    assign m_min = (&rdata_reg.minute)    || (rdata_reg.minute    == req_reg.minute);
    assign m_hr  = (&rdata_reg.hour)      || (rdata_reg.hour      == req_reg.hour);
    assign m_md  = (&rdata_reg.month_day) || (rdata_reg.month_day == req_reg.month_day);
    assign m_mo  = (&rdata_reg.month)     || (rdata_reg.month     == req_reg.month);
    assign m_wd  = (&rdata_reg.week_day)  || (rdata_reg.week_day  == req_reg.week_day);
    assign tick_hit = cmp_ev && m_min && m_hr && ((m_md && m_mo) || m_wd);
    assign rem_hit  = cmp_ev && ((op_reg == ACT_REMOVE_ID) ? (rdata_reg.id == req_reg.id)
                                                           : (rdata_reg.handle == req_reg.handle));

    always_comb
    begin
        wr_rec    = req_reg;
        wr_rec.id = id_new;
    end

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        bad_next         = bad_reg;
        req_next         = req_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_v_next       = cmp_v_reg;
        cmp_idx_next     = cmp_idx_reg;
        valid_next       = valid_reg;
        cnt_next         = cnt_reg;
        pend_v_next      = pend_v_reg;
        pend_id_next     = pend_id_reg;
        pend_handle_next = pend_handle_reg;
        id_counter_next  = id_counter_reg;
        out_v_next       = out_v_reg && rsp_stall;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_handle_next  = out_handle_reg;
        out_count_next   = out_count_reg;
        out_last_next    = out_last_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        cmp_retire       = 1'b1;
        done             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = action;
                    bad_next    = (action == ACT_SCHEDULE) && field_bad;
                    req_next    = '{id: entry_id, handle: task_handle, minute: minute,
                                    hour: hour, month_day: month_day, month: month,
                                    week_day: week_day};
                    rd_idx_next = ((action == ACT_SCHEDULE) && field_bad) ? CW'(ENTRIES) : '0;
                    cnt_next    = '0;
                    pend_v_next = 1'b0;
                    cmp_v_next  = 1'b0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cmp_v_reg)
                begin
                    unique case (op_reg) inside
                        ACT_SCHEDULE:
                        begin
                            if (!cmp_ev)
                            begin
                                if (out_free)
                                begin
                                    wr_en                    = 1'b1;
                                    id_counter_next          = id_new;
                                    valid_next[cmp_idx_reg]  = 1'b1;
                                    out_v_next               = 1'b1;
                                    out_status_next          = STAT_SCHEDULED;
                                    out_id_next              = id_new;
                                    out_handle_next          = req_reg.handle;
                                    out_count_next           = '0;
                                    out_last_next            = 1'b1;
                                    done                     = 1'b1;
                                end
                                else
                                begin
                                    cmp_retire = 1'b0;
                                end
                            end
                        end
                        ACT_REMOVE_ID, ACT_REMOVE_HANDLE:
                        begin
                            if (rem_hit)
                            begin
                                valid_next[cmp_idx_reg] = 1'b0;
                                cnt_next                = cnt_reg + 1'b1;
                            end
                        end
                        ACT_TICK:
                        begin
                            if (tick_hit)
                            begin
                                if (pend_v_reg && !out_free)
                                begin
                                    cmp_retire = 1'b0;
                                end
                                else
                                begin
                                    if (pend_v_reg)
                                    begin
                                        out_v_next      = 1'b1;
                                        out_status_next = STAT_MATCH;
                                        out_id_next     = pend_id_reg;
                                        out_handle_next = pend_handle_reg;
                                        out_count_next  = '0;
                                        out_last_next   = 1'b0;
                                    end
                                    pend_v_next      = 1'b1;
                                    pend_id_next     = rdata_reg.id;
                                    pend_handle_next = rdata_reg.handle;
                                end
                            end
                        end
                    endcase
                end

                if (done)
                begin
                    cmp_v_next = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    if (cmp_v_reg && cmp_retire)
                        cmp_v_next = 1'b0;
                    if ((!cmp_v_reg || cmp_retire) && !scan_end)
                    begin
                        rd_en        = 1'b1;
                        cmp_v_next   = 1'b1;
                        cmp_idx_next = rd_idx_reg[IW-1:0];
                        rd_idx_next  = rd_idx_reg + 1'b1;
                    end
                    else if (!cmp_v_reg && scan_end && out_free)
                    begin
                        out_v_next     = 1'b1;
                        out_id_next    = '0;
                        out_handle_next = '0;
                        out_count_next = '0;
                        out_last_next  = 1'b1;
                        unique case (op_reg) inside
                            ACT_SCHEDULE:
                                out_status_next = bad_reg ? STAT_BAD_FIELD : STAT_FULL;
                            ACT_REMOVE_ID, ACT_REMOVE_HANDLE:
                            begin
                                out_status_next = STAT_REMOVED;
                                out_count_next  = 5'(cnt_reg);
                            end
                            ACT_TICK:
                            begin
                                if (pend_v_reg)
                                begin
                                    out_status_next = STAT_MATCH;
                                    out_id_next     = pend_id_reg;
                                    out_handle_next = pend_handle_reg;
                                end
                                else
                                begin
                                    out_status_next = STAT_NO_MATCH;
                                end
                            end
                        endcase
                        pend_v_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= ACT_SCHEDULE;
            bad_reg         <= 1'b0;
            req_reg         <= '0;
            rd_idx_reg      <= '0;
            cmp_v_reg       <= 1'b0;
            cmp_idx_reg     <= '0;
            valid_reg       <= '0;
            cnt_reg         <= '0;
            pend_v_reg      <= 1'b0;
            pend_id_reg     <= '0;
            pend_handle_reg <= '0;
            id_counter_reg  <= '0;
            out_v_reg       <= 1'b0;
            out_status_reg  <= STAT_SCHEDULED;
            out_id_reg      <= '0;
            out_handle_reg  <= '0;
            out_count_reg   <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            bad_reg         <= bad_next;
            req_reg         <= req_next;
            rd_idx_reg      <= rd_idx_next;
            cmp_v_reg       <= cmp_v_next;
            cmp_idx_reg     <= cmp_idx_next;
            valid_reg       <= valid_next;
            cnt_reg         <= cnt_next;
            pend_v_reg      <= pend_v_next;
            pend_id_reg     <= pend_id_next;
            pend_handle_reg <= pend_handle_next;
            id_counter_reg  <= id_counter_next;
            out_v_reg       <= out_v_next;
            out_status_reg  <= out_status_next;
            out_id_reg      <= out_id_next;
            out_handle_reg  <= out_handle_next;
            out_count_reg   <= out_count_next;
            out_last_reg    <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[cmp_idx_reg] <= wr_rec;
        if (rd_en)
            rdata_reg <= mem[rd_idx_reg[IW-1:0]];
    end

    assign req_stall     = (state_reg != S_IDLE);
    assign rsp_valid     = out_v_reg;
    assign status        = out_status_reg;
    assign result_id     = out_id_reg;
    assign result_handle = out_handle_reg;
    assign removed_count = out_count_reg;
    assign last          = out_last_reg;

`include "assert_macros.svh"

    `ASSERT_PROP(a_accept_scan, (req_valid && !req_stall) |=> (state_reg == S_SCAN), "request accepted without starting a scan")
    `ASSERT_NEVER(a_cmp_in_scan, cmp_v_reg && (state_reg != S_SCAN), "compare stage busy outside a scan")
    `ASSERT_NEVER(a_pend_tick, pend_v_reg && (op_reg != ACT_TICK), "pending match outside a tick")
    `ASSERT_NEVER(a_write_sched, wr_en && (op_reg != ACT_SCHEDULE), "entry write outside a schedule")
    `ASSERT_PROP(a_id_hold, !wr_en |=> $stable(id_counter_reg), "id counter moved without a store")

endmodule

>>> test/testbench.sv
// Testbench for the cron entry match table: directed and random requests checked by a predictor.
module testbench;
    import cemt_pkg::*;

    localparam int DEPTH         = DEFAULT_ENTRIES;
    localparam int RANDOM_ITEMS  = 210;
    localparam int SETTLE_CYCLES = 2 * (DEPTH + 3) + 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam logic [7:0] FLOOD_HANDLE = 8'hC3;

    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_WATCH = 2;

    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;

    typedef struct {
        logic [1:0]        act;
        logic signed [6:0] minute;
        logic signed [5:0] hour;
        logic signed [5:0] month_day;
        logic signed [4:0] month;
        logic signed [3:0] week_day;
        logic [15:0]       entry_id;
        logic [7:0]        task_handle;
    } request_t;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] id;
        logic [7:0]  handle;
        logic [4:0]  count;
        logic        last;
    } response_t;

    class cron_table_tracker;
        request_t    slot_rec[DEPTH];
        bit          slot_live[DEPTH];
        logic [15:0] id_count;
        response_t   owed_responses[$];
        int errors;
        int n_req;
        int n_stored;
        int n_bad;
        int n_full;
        int n_removed;
        int n_hits;
        int n_miss;

        function new();
            id_count = 16'd0;
        endfunction

        static function bit pattern_ok(int v, int lo, int hi);
            return v == -1 || (v >= lo && v <= hi);
        endfunction

        static function bit field_hit(int value, int pattern);
            return pattern == -1 || pattern == value;
        endfunction

        function int pending();
            return owed_responses.size();
        endfunction

        function int random_live_slot();
            int picks[$];
            for (int i = 0; i < DEPTH; i++)
                if (slot_live[i]) picks = {picks, i};
            if (picks.size() == 0) return -1;
            return picks[$urandom_range(0, picks.size() - 1)];
        endfunction

        function void owe(logic [2:0] st, logic [15:0] id, logic [7:0] h, logic [4:0] cnt,
                          logic lst);
            response_t r;
            r.status = st;
            r.id     = id;
            r.handle = h;
            r.count  = cnt;
            r.last   = lst;
            owed_responses = {owed_responses, r};
        endfunction

        function void note_request(request_t r);
            int slot;
            int hits[$];
            logic [4:0] dropped;
            bit mh;
            n_req++;
            case (r.act)
                ACT_SCHEDULE:
                begin
                    if (!pattern_ok(r.minute, 0, 59) || !pattern_ok(r.hour, 0, 23) ||
                        !pattern_ok(r.month_day, 1, 31) || !pattern_ok(r.month, 1, 12) ||
                        !pattern_ok(r.week_day, 0, 6))
                    begin
                        owe(STAT_BAD_FIELD, 16'd0, 8'd0, 5'd0, 1'b1);
                        n_bad++;
                    end
                    else
                    begin
                        slot = -1;
                        for (int i = DEPTH - 1; i >= 0; i--)
                            if (!slot_live[i]) slot = i;
                        if (slot < 0)
                        begin
                            owe(STAT_FULL, 16'd0, 8'd0, 5'd0, 1'b1);
                            n_full++;
                        end
                        else
                        begin
                            id_count = id_count + 16'd1;
                            slot_rec[slot] = r;
                            slot_rec[slot].entry_id = id_count;
                            slot_live[slot] = 1'b1;
                            owe(STAT_SCHEDULED, id_count, r.task_handle, 5'd0, 1'b1);
                            n_stored++;
                        end
                    end
                end
                ACT_TICK:
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (slot_live[i])
                        begin
                            mh = field_hit(r.minute, slot_rec[i].minute) &&
                                 field_hit(r.hour, slot_rec[i].hour);
                            if (mh && ((field_hit(r.month_day, slot_rec[i].month_day) &&
                                        field_hit(r.month, slot_rec[i].month)) ||
                                       field_hit(r.week_day, slot_rec[i].week_day)))
                                hits = {hits, i};
                        end
                    end
                    if (hits.size() == 0)
                    begin
                        owe(STAT_NO_MATCH, 16'd0, 8'd0, 5'd0, 1'b1);
                        n_miss++;
                    end
                    foreach (hits[k])
                        owe(STAT_MATCH, slot_rec[hits[k]].entry_id, slot_rec[hits[k]].task_handle,
                            5'd0, k == hits.size() - 1);
                    n_hits += hits.size();
                end
                default:
                begin
                    dropped = 5'd0;
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (slot_live[i] &&
                            ((r.act == ACT_REMOVE_ID && slot_rec[i].entry_id == r.entry_id) ||
                             (r.act == ACT_REMOVE_HANDLE &&
                              slot_rec[i].task_handle == r.task_handle)))
                        begin
                            slot_live[i] = 1'b0;
                            dropped = dropped + 5'd1;
                        end
                    end
                    owe(STAT_REMOVED, 16'd0, 8'd0, dropped, 1'b1);
                    n_removed += dropped;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_response(response_t got);
            response_t want;
            if (owed_responses.size() == 0)
            begin
                $error("response with nothing owed: status %0d id %0d handle %0d",
                       got.status, got.id, got.handle);
                errors++;
                return;
            end
            want = owed_responses.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("result_id", want.id, got.id);
            compare_field("result_handle", want.handle, got.handle);
            compare_field("removed_count", want.count, got.count);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              req_valid     = 1'b0;
    logic              req_stall;
    logic [1:0]        action        = '0;
    logic signed [6:0] minute        = '0;
    logic signed [5:0] hour          = '0;
    logic signed [5:0] month_day     = '0;
    logic signed [4:0] month         = '0;
    logic signed [3:0] week_day      = '0;
    logic [15:0]       entry_id      = '0;
    logic [7:0]        task_handle   = '0;
    logic              rsp_valid;
    logic              rsp_stall     = 1'b0;
    logic [2:0]        status;
    logic [15:0]       result_id;
    logic [7:0]        result_handle;
    logic [4:0]        removed_count;
    logic              last;

    cron_table_tracker sb;
    int unsigned cycle_count = 0;
    int burst_left = 0;
    int stall_style = STALL_NONE;
    int style_left = 0;
    bit rush = 1'b0;

    cron_entry_match_table_top #(
        .ENTRIES(DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .action(action),
        .minute(minute),
        .hour(hour),
        .month_day(month_day),
        .month(month),
        .week_day(week_day),
        .entry_id(entry_id),
        .task_handle(task_handle),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .status(status),
        .result_id(result_id),
        .result_handle(result_handle),
        .removed_count(removed_count),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("cron_entry_match_table_top regression: fail");
        $finish;
    end

    always @(negedge clk)
    begin
        if (rush)
            rsp_stall <= 1'b0;
        else
        begin
            if (style_left == 0)
            begin
                stall_style <= $urandom_range(STALL_NONE, STALL_PERIODIC);
                style_left  <= $urandom_range(16, 96);
            end
            else
                style_left <= style_left - 1;
            case (stall_style)
                STALL_NONE:   rsp_stall <= 1'b0;
                STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
                default:      rsp_stall <= (cycle_count % 11) < 5;
            endcase
        end
    end

    always @(posedge clk)
    begin
        response_t got;
        request_t  seen;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            got.status = status;
            got.id     = result_id;
            got.handle = result_handle;
            got.count  = removed_count;
            got.last   = last;
            sb.check_response(got);
        end
        if (rst_n && req_valid && !req_stall)
        begin
            seen.act         = action;
            seen.minute      = minute;
            seen.hour        = hour;
            seen.month_day   = month_day;
            seen.month       = month;
            seen.week_day    = week_day;
            seen.entry_id    = entry_id;
            seen.task_handle = task_handle;
            sb.note_request(seen);
        end
    end

    function automatic request_t make_req(logic [1:0] act, int mi, int hr, int md, int mo,
                                          int wd, int eid, int th);
        request_t r;
        r.act         = act;
        r.minute      = 7'(mi);
        r.hour        = 6'(hr);
        r.month_day   = 6'(md);
        r.month       = 5'(mo);
        r.week_day    = 4'(wd);
        r.entry_id    = 16'(eid);
        r.task_handle = 8'(th);
        return r;
    endfunction

    function automatic int any_or(int lo, int hi);
        return ($urandom_range(0, 3) == 0) ? -1 : int'($urandom_range(hi, lo));
    endfunction

    function automatic request_t random_request(int mix);
        request_t r;
        request_t e;
        int roll;
        int s;
        r = make_req(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom);
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  r.act = roll < 65 ? ACT_SCHEDULE : roll < 80 ? ACT_TICK :
                               roll < 90 ? ACT_REMOVE_ID : ACT_REMOVE_HANDLE;
            MIX_DRAIN: r.act = roll < 20 ? ACT_SCHEDULE : roll < 50 ? ACT_TICK :
                               roll < 75 ? ACT_REMOVE_ID : ACT_REMOVE_HANDLE;
            default:   r.act = roll < 30 ? ACT_SCHEDULE : roll < 75 ? ACT_TICK :
                               roll < 88 ? ACT_REMOVE_ID : ACT_REMOVE_HANDLE;
        endcase
        s = sb.random_live_slot();
        case (r.act)
            ACT_SCHEDULE:
            begin
                r.minute    = 7'(any_or(0, 59));
                r.hour      = 6'(any_or(0, 23));
                r.month_day = 6'(any_or(1, 31));
                r.month     = 5'(any_or(1, 12));
                r.week_day  = 4'(any_or(0, 6));
                if ($urandom_range(0, 99) < 60) r.task_handle = 8'($urandom_range(0, 7));
                if ($urandom_range(0, 9) == 0)
                begin
                    case ($urandom_range(0, 4))
                        0: do r.minute = 7'($urandom);
                           while (cron_table_tracker::pattern_ok(r.minute, 0, 59));
                        1: do r.hour = 6'($urandom);
                           while (cron_table_tracker::pattern_ok(r.hour, 0, 23));
                        2: do r.month_day = 6'($urandom);
                           while (cron_table_tracker::pattern_ok(r.month_day, 1, 31));
                        3: do r.month = 5'($urandom);
                           while (cron_table_tracker::pattern_ok(r.month, 1, 12));
                        default: do r.week_day = 4'($urandom);
                           while (cron_table_tracker::pattern_ok(r.week_day, 0, 6));
                    endcase
                end
            end
            ACT_REMOVE_ID:
                if (s >= 0 && $urandom_range(0, 9) < 7) r.entry_id = sb.slot_rec[s].entry_id;
            ACT_REMOVE_HANDLE:
                if (s >= 0 && $urandom_range(0, 9) < 7)
                    r.task_handle = sb.slot_rec[s].task_handle;
                else if ($urandom_range(0, 1) == 0)
                    r.task_handle = 8'($urandom_range(0, 7));
            default:
            begin
                roll = $urandom_range(0, 9);
                if (roll < 6 && s >= 0)
                begin
                    e = sb.slot_rec[s];
                    r.minute    = e.minute == -1 ? 7'($urandom_range(0, 59)) : e.minute;
                    r.hour      = e.hour == -1 ? 6'($urandom_range(0, 23)) : e.hour;
                    r.month_day = e.month_day == -1 ? 6'($urandom_range(1, 31)) : e.month_day;
                    r.month     = e.month == -1 ? 5'($urandom_range(1, 12)) : e.month;
                    r.week_day  = e.week_day == -1 ? 4'($urandom_range(0, 6)) : e.week_day;
                    case ($urandom_range(0, 2))
                        0: r.week_day = 4'($urandom_range(0, 6));
                        1: r.month_day = 6'($urandom_range(1, 31));
                        default: ;
                    endcase
                end
                else if (roll < 8)
                begin
                    r.minute    = 7'($urandom_range(0, 59));
                    r.hour      = 6'($urandom_range(0, 23));
                    r.month_day = 6'($urandom_range(1, 31));
                    r.month     = 5'($urandom_range(1, 12));
                    r.week_day  = 4'($urandom_range(0, 6));
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_request(input request_t r);
        req_valid   <= 1'b1;
        action      <= r.act;
        minute      <= r.minute;
        hour        <= r.hour;
        month_day   <= r.month_day;
        month       <= r.month;
        week_day    <= r.week_day;
        entry_id    <= r.entry_id;
        task_handle <= r.task_handle;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
    endtask

    initial
    begin
        request_t plan[$];
        int mix;
        sb = new();
        mix = MIX_FILL;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        plan = {plan, make_req(ACT_TICK, 0, 0, 0, 0, 0, 0, 0)};
        plan = {plan, make_req(ACT_REMOVE_ID, 0, 0, 0, 0, 0, 0, 0)};
        plan = {plan, make_req(ACT_REMOVE_HANDLE, 0, 0, 0, 0, 0, 65535, 0)};
        plan = {plan, make_req(ACT_SCHEDULE, -1, -1, -1, -1, -1, 65535, 255)};
        plan = {plan, make_req(ACT_SCHEDULE, 59, 23, 31, 12, 6, 0, 0)};
        plan = {plan, make_req(ACT_SCHEDULE, 0, 0, 1, 1, 0, 0, 8'h5A)};
        plan = {plan, make_req(ACT_SCHEDULE, 60, 0, 1, 1, 0, 0, 1)};
        plan = {plan, make_req(ACT_SCHEDULE, -64, 0, 1, 1, 0, 0, 1)};
        plan = {plan, make_req(ACT_SCHEDULE, 0, 24, 1, 1, 0, 0, 1)};
        plan = {plan, make_req(ACT_SCHEDULE, 0, 0, 0, 1, 0, 0, 1)};
        plan = {plan, make_req(ACT_SCHEDULE, 0, 0, 1, 13, 0, 0, 1)};
        plan = {plan, make_req(ACT_SCHEDULE, 0, 0, 1, 1, 7, 0, 1)};
        plan = {plan, make_req(ACT_SCHEDULE, 0, 0, 1, 1, -8, 0, 1)};
        plan = {plan, make_req(ACT_TICK, 59, 23, 31, 12, 6, 0, 0)};
        plan = {plan, make_req(ACT_TICK, 0, 0, 2, 5, 0, 0, 0)};
        plan = {plan, make_req(ACT_TICK, 0, 0, 1, 1, 3, 0, 0)};
        plan = {plan, make_req(ACT_TICK, -1, -1, -1, -1, -1, 0, 0)};
        plan = {plan, make_req(ACT_TICK, 63, 31, 31, 15, 7, 0, 0)};
        plan = {plan, make_req(ACT_REMOVE_HANDLE, 0, 0, 0, 0, 0, 0, 255)};
        plan = {plan, make_req(ACT_REMOVE_ID, 0, 0, 0, 0, 0, 2, 0)};
        plan = {plan, make_req(ACT_TICK, 0, 0, 1, 1, 0, 0, 0)};
        plan = {plan, make_req(ACT_REMOVE_HANDLE, 0, 0, 0, 0, 0, 0, 8'h5A)};
        foreach (plan[i])
        begin
            send_request(plan[i]);
            pace();
        end
        wait_drained();

        // fill the table one past capacity with the receiver never stalling, then clear it
        rush <= 1'b1;
        repeat (DEPTH + 1)
            send_request(make_req(ACT_SCHEDULE, -1, -1, -1, -1, -1, $urandom, FLOOD_HANDLE));
        send_request(make_req(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0));
        send_request(make_req(ACT_REMOVE_HANDLE, 0, 0, 0, 0, 0, 0, FLOOD_HANDLE));
        rush <= 1'b0;

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0) mix = $urandom_range(MIX_FILL, MIX_WATCH);
            send_request(random_request(mix));
            pace();
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("%0d requests: %0d stored, %0d bad patterns, %0d table-full, %0d entries removed",
                 sb.n_req, sb.n_stored, sb.n_bad, sb.n_full, sb.n_removed);
        $display("ticks reported %0d entry hits and %0d empty scans; id counter at %0d",
                 sb.n_hits, sb.n_miss, sb.id_count);
        if (sb.errors == 0)
            $display("cron_entry_match_table_top regression: pass");
        else
            $display("cron_entry_match_table_top regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/cemt_pkg.sv
hdl/cron_entry_match_table_top.sv
test/testbench.sv
